// ===== rtl/bfn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfn_pkg: shared types and constants of the bitmap find-next-bit block
// Sizes of the bitmap, opcode and command kind codes, the queue word type
// and the lowest-set-bit encoder used by the scan engine.
// ----------------------------------------------------------------------------
package bfn_pkg;

  // bitmap geometry
  localparam int NUM_WORDS  = 64;
  localparam int WORD_BITS  = 64;
  localparam int TOTAL_BITS = NUM_WORDS * WORD_BITS;
  localparam int WORD_AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_SEL_W  = 6;

  // field widths of the interface
  localparam int OP_W   = 2;
  localparam int WIDX_W = 6;
  localparam int IDX_W  = 13;

  // opcodes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_SET   = 2'd1;
  localparam logic [OP_W-1:0] OP_ZERO  = 2'd2;

  // command kinds after classification
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  // command queue depth
  localparam int QDEPTH = 2;
  localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  // one classified command word
  typedef struct packed {
    logic [1:0]           kind;
    logic                 want_zero;
    logic [WORD_AW-1:0]   waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [IDX_W-1:0]     limit;
    logic [WORD_AW-1:0]   first_word;
    logic [WORD_AW-1:0]   last_word;
    logic [BIT_SEL_W-1:0] start_lo;
    logic [BIT_SEL_W-1:0] tail;
  } cmd_t;

  // position of the lowest set bit of a word (zero for an empty word)
  function automatic logic [BIT_SEL_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
    logic [BIT_SEL_W-1:0] n;
    n = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) n = BIT_SEL_W'(i);
    end
    return n;
  endfunction

endpackage

// ===== rtl/bfn_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfn_ram: generic single write, single read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bfn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bfn_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfn_front: command intake and classification
// Decodes each accepted word, works out the word range and edge positions of
// a search, and holds the result in a short queue for the scan engine.
// ----------------------------------------------------------------------------
module bfn_front (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [bfn_pkg::OP_W-1:0]                opcode,
  input  logic [bfn_pkg::WIDX_W-1:0]              word_index,
  input  logic [bfn_pkg::WORD_BITS-1:0]           word_data,
  input  logic [bfn_pkg::IDX_W-1:0]               start_bit,
  input  logic [bfn_pkg::IDX_W-1:0]               limit_bits,
  output logic                                    q_valid,
  output bfn_pkg::cmd_t                           q_head,
  input  logic                                    q_pop
);
  import bfn_pkg::*;

  cmd_t           q [QDEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  cmd_t           cmd;
  logic           keep;
  logic           push;

  // classify the incoming word
  always_comb begin
    int span_i;
    span_i = (int'(limit_bits) < TOTAL_BITS) ? int'(limit_bits) : TOTAL_BITS;
    cmd            = '0;
    cmd.waddr      = WORD_AW'(word_index);
    cmd.wdata      = word_data;
    cmd.limit      = limit_bits;
    cmd.want_zero  = (opcode == OP_ZERO);
    cmd.first_word = WORD_AW'(start_bit >> BIT_SEL_W);
    cmd.last_word  = WORD_AW'((span_i - 1) >> BIT_SEL_W);
    cmd.start_lo   = start_bit[BIT_SEL_W-1:0];
    cmd.tail       = BIT_SEL_W'(span_i);
    keep           = 1'b0;
    unique case (opcode) inside
      OP_WRITE: begin
        cmd.kind = KIND_WRITE;
        keep     = (int'(word_index) < NUM_WORDS);
      end
      OP_SET, OP_ZERO: begin
        cmd.kind = (int'(start_bit) >= span_i) ? KIND_EMPTY : KIND_SEARCH;
        keep     = 1'b1;
      end
      default: begin
        cmd.kind = KIND_EMPTY;
        keep     = 1'b0;
      end
    endcase
  end

  assign busy    = (count == QCW'(QDEPTH));
  assign push    = start && !busy && keep;
  assign q_valid = (count != '0);
  assign q_head  = q[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cmd;
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !q_pop) count <= count + 1'b1;
      else if (!push && q_pop) count <= count - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("command queue over-filled");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty command queue");

endmodule

// ===== rtl/bfn_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfn_back: bitmap store and scan engine
// Executes queued commands in order: word writes go to the bitmap memory,
// searches read one bitmap word per cycle and stop at the first match.
// ----------------------------------------------------------------------------
module bfn_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  bfn_pkg::cmd_t              q_head,
  output logic                       q_pop,
  output logic                       done,
  output logic [bfn_pkg::IDX_W-1:0]  found_index,
  output logic                       found
);
  import bfn_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                 state;
  cmd_t                 cur;
  logic [WORD_AW-1:0]   rd_word;
  logic [WORD_AW-1:0]   ev_word;
  logic                 ev_valid;
  logic                 rvalid_q;
  logic [NUM_WORDS-1:0] wvalid;
  logic [WORD_BITS-1:0] rdata;
  logic                 ram_we;
  logic [WORD_BITS-1:0] word_m;
  logic                 hit;
  logic [BIT_SEL_W-1:0] hit_pos;

  assign q_pop  = (state == ST_IDLE) && q_valid;
  assign ram_we = q_pop && (q_head.kind == KIND_WRITE);

  // bitmap memory
  bfn_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_head.waddr),
    .wdata (q_head.wdata),
    .raddr (rd_word),
    .rdata (rdata)
  );

  // written flags: an unwritten word reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
    end else if (ram_we) begin
      wvalid[q_head.waddr] <= 1'b1;
    end
  end

  // polarity and edge masks on the word under evaluation
  always_comb begin
    logic [WORD_BITS-1:0] data;
    data   = rvalid_q ? rdata : '0;
    word_m = data ^ {WORD_BITS{cur.want_zero}};
    if (ev_word == cur.first_word) word_m = word_m & ({WORD_BITS{1'b1}} << cur.start_lo);
    if ((ev_word == cur.last_word) && (cur.tail != '0)) begin
      word_m = word_m & ((WORD_BITS'(1) << cur.tail) - WORD_BITS'(1));
    end
    hit     = (word_m != '0);
    hit_pos = lowest_set(word_m);
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ev_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          ev_valid <= 1'b0;
          if (q_pop) begin
            cur     <= q_head;
            rd_word <= q_head.first_word;
            if (q_head.kind == KIND_SEARCH) begin
              state <= ST_SCAN;
            end else if (q_head.kind == KIND_EMPTY) begin
              done        <= 1'b1;
              found       <= 1'b0;
              found_index <= q_head.limit;
            end
          end
        end
        ST_SCAN: begin
          ev_valid <= 1'b1;
          ev_word  <= rd_word;
          rvalid_q <= wvalid[rd_word];
          if (rd_word != cur.last_word) rd_word <= rd_word + 1'b1;
          if (ev_valid && hit) begin
            done        <= 1'b1;
            found       <= 1'b1;
            found_index <= IDX_W'({ev_word, hit_pos});
            state       <= ST_IDLE;
            ev_valid    <= 1'b0;
          end else if (ev_valid && (ev_word == cur.last_word)) begin
            done        <= 1'b1;
            found       <= 1'b0;
            found_index <= cur.limit;
            state       <= ST_IDLE;
            ev_valid    <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_rd_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_word >= cur.first_word && rd_word <= cur.last_word))
    else $error("read address outside search range");

  a_ev_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && ev_valid) |-> (ev_word <= cur.last_word))
    else $error("evaluated word past last word");

  a_scan_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && ev_valid && (hit || ev_word == cur.last_word))
      |=> (done && state == ST_IDLE))
    else $error("scan did not finish with a result");

endmodule

// ===== rtl/bitmap_find_next_bit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_find_next_bit: 4096-bit bitmap with find-next-set/zero search
// Top level: command intake, queue and scan engine.
// ----------------------------------------------------------------------------
// Usage:
//   A command word is taken when start is high and busy is low. Opcode 0
//   writes word_data to bitmap word word_index and gives no result. Opcode 1
//   or 2 searches for the next set or zero bit from start_bit up to, not
//   including, limit_bits. Opcode 3 is dropped.
//   Each search gives one result word: done is high for exactly one cycle
//   with found_index and found; when nothing matches, found is 0 and
//   found_index is limit_bits. The receiver has no way to stall.
//   Commands go through a two-entry queue and execute strictly in order.
//   An accepted command is registered in the queue before the scan engine
//   takes it. A write goes straight to the bitmap memory. A search that starts
//   at or past the end of its range gives its no-match result with no read; else
//   the engine reads the words of its range in order (up to 64 words) through
//   the single read port of the bitmap memory, stops at the first match and
//   takes no new command until done. Reset empties the queue and marks every
//   bitmap word as zero at once; commands are taken in the first cycle after reset.
// ----------------------------------------------------------------------------
module bitmap_find_next_bit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bfn_pkg::OP_W-1:0]      opcode,
  input  logic [bfn_pkg::WIDX_W-1:0]    word_index,
  input  logic [bfn_pkg::WORD_BITS-1:0] word_data,
  input  logic [bfn_pkg::IDX_W-1:0]     start_bit,
  input  logic [bfn_pkg::IDX_W-1:0]     limit_bits,
  output logic                          done,
  output logic [bfn_pkg::IDX_W-1:0]     found_index,
  output logic                          found
);
  import bfn_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_head;

  // intake and queue
  bfn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .word_index (word_index),
    .word_data  (word_data),
    .start_bit  (start_bit),
    .limit_bits (limit_bits),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop)
  );

  // bitmap store and scan engine
  bfn_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .done        (done),
    .found_index (found_index),
    .found       (found)
  );

endmodule
